### rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on every rising clock edge outside reset
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising clock edge, reset included
`define LMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/lms_pkg.sv
// constants and helper functions for the lag member select block
`default_nettype none
package lms_pkg;

	localparam int NUM_PORTS_DEF   = 64;
	localparam int GROUP_COUNT_DEF = 256;

	localparam int GROUP_IDX_W = 8;
	localparam int BITMAP_W    = 64;
	localparam int HASH_W      = 16;
	localparam int CHOSEN_W    = 6;
	localparam int TOTAL_W     = 7;

	localparam int CHUNK_W     = 8;
	localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);
	localparam int CHUNK_IDX_W = $clog2(CHUNK_W);

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	function automatic logic [CHUNK_CNT_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] bits);
		logic [CHUNK_CNT_W-1:0] n;
		n = '0;
		for (int b = 0; b < CHUNK_W; b++) begin
			n = n + CHUNK_CNT_W'(bits[b]);
		end
		return n;
	endfunction

	// position of the set bit with the given rank (from 1) inside one chunk
	function automatic logic [CHUNK_IDX_W-1:0] find_rank(input logic [CHUNK_W-1:0] bits,
		input logic [CHUNK_CNT_W-1:0] rank);
		logic [CHUNK_CNT_W-1:0] seen;
		logic [CHUNK_IDX_W-1:0] pos;
		logic                   got;
		seen = '0;
		pos  = '0;
		got  = 1'b0;
		for (int b = 0; b < CHUNK_W; b++) begin
			if (bits[b] && !got) begin
				seen = seen + 1'b1;
				if (seen == rank) begin
					pos = CHUNK_IDX_W'(b);
					got = 1'b1;
				end
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

### rtl/lms_table.sv
// group table memory: one row per group holding count and member bitmap
`default_nettype none
module lms_table #(
	parameter int GROUP_COUNT = 256,
	parameter int ROW_W       = 71
) (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(GROUP_COUNT)-1:0] wr_addr,
	input  wire logic [ROW_W-1:0]               wr_data,
	input  wire logic                           rd_en,
	input  wire logic [$clog2(GROUP_COUNT)-1:0] rd_addr,
	output logic      [ROW_W-1:0]               rd_data
);

	logic [ROW_W-1:0] mem [GROUP_COUNT];
	logic [ROW_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/lag_member_select_top.sv
// top level: lag group table with hash based member port selection
// write: 8-bit popcount per cycle, then stored; out of range: done only, busy stays low
// select: 1 table read + 16 restoring modulo steps + 1 to ceil(NUM_PORTS/8) scan steps
// select on an empty or out of range group ends after the table read
// one item at a time; busy stays high until the done strobe, which is never stalled
// after reset a clearing pass zeroes every table row with busy high
`default_nettype none
`include "assert_macros.svh"
module lag_member_select_top #(
	parameter int NUM_PORTS   = lms_pkg::NUM_PORTS_DEF,
	parameter int GROUP_COUNT = lms_pkg::GROUP_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic [lms_pkg::GROUP_IDX_W-1:0] group_index,
	input  wire logic [lms_pkg::BITMAP_W-1:0]  member_bitmap,
	input  wire logic [lms_pkg::HASH_W-1:0]    flow_hash,
	output logic                               done,
	output logic      [lms_pkg::CHOSEN_W-1:0]  chosen_port,
	output logic      [lms_pkg::TOTAL_W-1:0]   member_total,
	output logic                               no_member
);

	import lms_pkg::*;

	localparam int CW     = $clog2(NUM_PORTS + 1);
	localparam int PORTW  = $clog2(NUM_PORTS);
	localparam int NCHUNK = (NUM_PORTS + CHUNK_W - 1) / CHUNK_W;
	localparam int PADW   = NCHUNK * CHUNK_W;
	localparam int STEPW  = $clog2(NCHUNK + 1);
	localparam int AW     = $clog2(GROUP_COUNT);
	localparam int IW     = ((AW > GROUP_IDX_W) ? AW : GROUP_IDX_W) + 1;
	localparam int ROW_W  = CW + NUM_PORTS;
	localparam int MODW   = $clog2(HASH_W);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_READ   = 6'b000100,
		S_COUNT  = 6'b001000,
		S_MOD    = 6'b010000,
		S_SCAN   = 6'b100000
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      addr_q;
	logic               range_q;
	logic [NUM_PORTS-1:0] bitmap_q;
	logic [PADW-1:0]    scan_q;
	logic [CW-1:0]      cnt_q;
	logic [STEPW-1:0]   step_q;
	logic [HASH_W-1:0]  hash_q;
	logic [CW-1:0]      rem_q;
	logic [MODW-1:0]    mod_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      seen_q;
	logic [PORTW-1:0]   base_q;
	logic               done_q;
	logic [PORTW-1:0]   chosen_q;
	logic [CW-1:0]      total_q;
	logic               nomem_q;

	logic               accept;
	logic [IW-1:0]      idx_wide;
	logic               in_range;
	logic [ROW_W-1:0]   rd_row;
	logic [CW-1:0]      row_cnt;
	logic [NUM_PORTS-1:0] row_bits;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;

	logic [CHUNK_W-1:0]     chunk;
	logic [CHUNK_CNT_W-1:0] chunk_pop;
	logic [CW-1:0]          cnt_sum;
	logic [CW:0]            seen_sum;
	logic                   hit;
	logic [CW-1:0]          rank_diff;
	logic [CHUNK_IDX_W-1:0] pos;
	logic [PORTW-1:0]       port_pick;
	logic [CW:0]            mod_sh;
	logic [CW:0]            mod_res;
	logic [CW-1:0]          rem_next;

	assign accept   = start && !busy;
	assign idx_wide = IW'(group_index);
	assign in_range = idx_wide < IW'(GROUP_COUNT);

	assign row_cnt  = rd_row[ROW_W-1 -: CW];
	assign row_bits = rd_row[NUM_PORTS-1:0];

	// shared chunk unit: popcount for writes, rank search for selects
	assign chunk     = scan_q[CHUNK_W-1:0];
	assign chunk_pop = pop_chunk(chunk);
	assign cnt_sum   = cnt_q + CW'(chunk_pop);
	assign seen_sum  = {1'b0, seen_q} + (CW + 1)'(chunk_pop);
	assign hit       = seen_sum >= {1'b0, k_q};
	assign rank_diff = k_q - seen_q;
	assign pos       = find_rank(chunk, rank_diff[CHUNK_CNT_W-1:0]);
	assign port_pick = base_q + PORTW'(pos);

	// one restoring modulo step
	assign mod_sh   = {rem_q, hash_q[HASH_W-1]};
	assign mod_res  = (mod_sh >= {1'b0, cnt_q}) ? (mod_sh - {1'b0, cnt_q}) : mod_sh;
	assign rem_next = mod_res[CW-1:0];

	assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_COUNT) && (step_q == STEPW'(1)));
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : {cnt_sum, bitmap_q};

	lms_table #(
		.GROUP_COUNT(GROUP_COUNT),
		.ROW_W      (ROW_W)
	) u_table (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (accept),
		.rd_addr(idx_wide[AW-1:0]),
		.rd_data(rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(GROUP_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_WRITE) begin
							if (in_range) begin
								state_q <= S_COUNT;
							end else begin
								done_q <= 1'b1;
							end
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (range_q && (row_cnt != '0)) begin
						state_q <= S_MOD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_COUNT: begin
					if (step_q == STEPW'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MOD: begin
					if (mod_q == MODW'(HASH_W - 1)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, loaded before use
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				addr_q   <= idx_wide[AW-1:0];
				range_q  <= in_range;
				bitmap_q <= member_bitmap[NUM_PORTS-1:0];
				scan_q   <= PADW'(member_bitmap[NUM_PORTS-1:0]);
				hash_q   <= flow_hash;
				cnt_q    <= '0;
				step_q   <= STEPW'(NCHUNK);
				if (accept) begin
					chosen_q <= '0;
					total_q  <= '0;
					nomem_q  <= 1'b0;
				end
			end
			S_READ: begin
				cnt_q    <= row_cnt;
				scan_q   <= PADW'(row_bits);
				rem_q    <= '0;
				mod_q    <= '0;
				seen_q   <= '0;
				base_q   <= '0;
				chosen_q <= '0;
				if (range_q) begin
					total_q <= row_cnt;
				end else begin
					total_q <= '0;
				end
				nomem_q  <= !(range_q && (row_cnt != '0));
			end
			S_COUNT: begin
				cnt_q  <= cnt_sum;
				scan_q <= scan_q >> CHUNK_W;
				step_q <= step_q - 1'b1;
				if (step_q == STEPW'(1)) begin
					total_q <= cnt_sum;
				end
			end
			S_MOD: begin
				rem_q  <= rem_next;
				hash_q <= hash_q << 1;
				mod_q  <= mod_q + 1'b1;
				// k counts set bits from 1
				k_q    <= rem_next + 1'b1;
			end
			S_SCAN: begin
				if (hit) begin
					chosen_q <= port_pick;
				end else begin
					seen_q <= seen_sum[CW-1:0];
					scan_q <= scan_q >> CHUNK_W;
					base_q <= base_q + PORTW'(CHUNK_W);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign chosen_port  = CHOSEN_W'(chosen_q);
	assign member_total = TOTAL_W'(total_q);
	assign no_member    = nomem_q;

	`LMS_ASSERT_ALWAYS(a_reset_quiet, clk, (!arst_n) |=> (!done && busy), "reset must hold busy and no strobe")
	`LMS_ASSERT(a_accept_moves, clk, arst_n, accept |=> (busy || done), "accepted beat must start work or finish")
	`LMS_ASSERT(a_empty_zero, clk, arst_n, (done && no_member) |-> (chosen_port == '0 && member_total == '0), "empty select must give zero port and total")
	`LMS_ASSERT(a_rank_bounds, clk, arst_n, (state_q == S_SCAN) |-> (k_q != '0 && k_q <= cnt_q), "member rank out of range")
	`LMS_ASSERT(a_no_idle_write, clk, arst_n, mem_we |-> (state_q != S_IDLE), "table written while idle")

endmodule
`default_nettype wire
